// ===== design/chxy_pkg.sv =====
package chxy_pkg;

    // Width of the X and Y readings and of the heading word.
    localparam int XY_W      = 16;
    localparam int HDG_W     = 15;

    // Readings are scaled by 2^8 before the rotation stages.
    localparam int PRESCALE_SH = 8;

    // Working width of the rotated vector. The gain of the rotation stays
    // below 1.65, so a magnitude of sqrt(2) * 2^23 fits easily.
    localparam int XW        = 27;

    // Angle accumulator in units of 2^-20 degree. It holds 360 degrees.
    localparam int ANG_FRAC  = 20;
    localparam int ZW        = 30;

    localparam int TABLE_LEN = 24;

    localparam logic signed [ZW-1:0] Z180 = ZW'(180 * (1 << ANG_FRAC));
    localparam logic signed [ZW-1:0] Z360 = ZW'(360 * (1 << ANG_FRAC));

    // atan(2^-i) in degrees, scaled by 2^20 and rounded to nearest.
    localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
        30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
        30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
        30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
        30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
        30'sd917,      30'sd458,      30'sd229,      30'sd115,
        30'sd57,       30'sd29,       30'sd14,       30'sd7
    };

    // Data that moves from one cell to the next.
    typedef struct packed {
        logic                 bypass;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] z;
    } t_stage;

endpackage

// ===== design/chxy_in_if.sv =====
interface chxy_in_if import chxy_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [XY_W-1:0] x_field;
    logic signed [XY_W-1:0] y_field;

    modport source (output valid, output x_field, output y_field, input ready);
    modport sink   (input valid, input x_field, input y_field, output ready);
endinterface

// ===== design/chxy_out_if.sv =====
interface chxy_out_if import chxy_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [HDG_W-1:0] heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

// ===== design/chxy_entry.sv =====
module chxy_entry import chxy_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chxy_in_if.sink    i_xy,
    input  logic       i_dn_ready,
    output logic       o_valid,
    output t_stage     o_data
);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    logic   load;

    logic signed [XW-1:0] xs_raw;
    logic signed [XW-1:0] ys_raw;

    assign load       = !r_valid || i_dn_ready;
    assign i_xy.ready = load;

    assign xs_raw = {{(XW-XY_W-PRESCALE_SH){i_xy.x_field[XY_W-1]}}, i_xy.x_field,
                     {PRESCALE_SH{1'b0}}};
    assign ys_raw = {{(XW-XY_W-PRESCALE_SH){i_xy.y_field[XY_W-1]}}, i_xy.y_field,
                     {PRESCALE_SH{1'b0}}};

    // A zero Y reading skips the rotation; the angle is exact from the start.
    // A negative X is turned by 180 degrees into the right half plane.
    always_comb begin
        n_data.bypass = 1'b0;
        n_data.xs     = xs_raw;
        n_data.ys     = ys_raw;
        n_data.z      = '0;
        if (i_xy.y_field == '0) begin
            n_data.bypass = 1'b1;
            n_data.xs     = '0;
            n_data.ys     = '0;
            n_data.z      = i_xy.x_field[XY_W-1] ? Z180 : '0;
        end else if (i_xy.x_field[XY_W-1]) begin
            n_data.xs = -xs_raw;
            n_data.ys = -ys_raw;
            n_data.z  = Z180;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_xy.valid;
        end
        if (load && i_xy.valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/chxy_cell.sv =====
module chxy_cell import chxy_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_up_valid,
    input  t_stage i_up_data,
    output logic   o_up_ready,
    input  logic   i_dn_ready,
    output logic   o_valid,
    output t_stage o_data
);

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    logic   load;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 ys_pos;

    assign load       = !r_valid || i_dn_ready;
    assign o_up_ready = load;

    assign dx     = i_up_data.ys >>> IDX;
    assign dy     = i_up_data.xs >>> IDX;
    assign ys_pos = !i_up_data.ys[XW-1] && (i_up_data.ys != '0);

    // One rotation step that drives Y toward zero.
    always_comb begin
        n_data = i_up_data;
        if (!i_up_data.bypass) begin
            if (ys_pos) begin
                n_data.xs = i_up_data.xs + dx;
                n_data.ys = i_up_data.ys - dy;
                n_data.z  = i_up_data.z + ATAN_TAB[IDX];
            end else begin
                n_data.xs = i_up_data.xs - dx;
                n_data.ys = i_up_data.ys + dy;
                n_data.z  = i_up_data.z - ATAN_TAB[IDX];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_up_valid;
        end
        if (load && i_up_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/chxy_final.sv =====
module chxy_final import chxy_pkg::*; #(
    parameter int FRAC_BITS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_up_valid,
    input  t_stage     i_up_data,
    output logic       o_up_ready,
    chxy_out_if.source o_hdg
);

    localparam int SH = ANG_FRAC - FRAC_BITS;
    localparam logic [ZW-1:0] HALF = ZW'(1 << (SH - 1));
    localparam logic [ZW-1:0] FULL = ZW'(360 * (1 << FRAC_BITS));

    logic             r_valid;
    logic [HDG_W-1:0] r_heading;
    logic             load;

    logic signed [ZW-1:0] z_wrap;
    logic [ZW-1:0]        z_pos;
    logic [ZW-1:0]        rounded;
    logic [ZW-1:0]        hdg_full;

    assign load       = !r_valid || o_hdg.ready;
    assign o_up_ready = load;

    // Fold negative angles up by a full turn, round half up to the output
    // unit and wrap a full turn back to zero.
    always_comb begin
        z_wrap   = i_up_data.z[ZW-1] ? (i_up_data.z + Z360) : i_up_data.z;
        z_pos    = z_wrap[ZW-1] ? '0 : z_wrap;
        rounded  = (z_pos + HALF) >> SH;
        hdg_full = (rounded >= FULL) ? (rounded - FULL) : rounded;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_up_valid;
        end
        if (load && i_up_valid) begin
            r_heading <= hdg_full[HDG_W-1:0];
        end
    end

    assign o_hdg.valid   = r_valid;
    assign o_hdg.heading = r_heading;

endmodule

// ===== design/compass_heading_from_xy_unit.sv =====
// Channel  Dir  Words carried              Handshake
// i_xy     in   x_field, y_field (s16)     valid / ready
// o_hdg    out  heading (u15, 1/64 deg)    valid / ready
//
// One word is taken in every cycle while a slot in the row is free. A heading
// passes through the entry cell, one cell per rotation stage, and the rounding
// cell, with at most 24 rotation stages in the row.
// Reset is synchronous and active low; it clears only the valid flags.
// A stall on o_hdg holds a cell only while its own word cannot move on, so
// empty slots in the row fill up and i_xy stays ready while any slot is free.
module compass_heading_from_xy_unit import chxy_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chxy_in_if.sink    i_xy,
    chxy_out_if.source o_hdg
);

    // The angle table has 24 entries, so the row never grows beyond that.
    localparam int N_CELLS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    // Position k of these arrays is the link between one cell and the next:
    // link 0 leaves the entry cell, link N_CELLS enters the rounding cell.
    logic   link_valid [N_CELLS+1];
    logic   link_ready [N_CELLS+1];
    t_stage link_data  [N_CELLS+1];

    // The entry cell scales the readings, turns the left half plane over by
    // 180 degrees, and marks a zero Y reading so that later cells pass it on.
    chxy_entry u_entry (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_xy       (i_xy),
        .i_dn_ready (link_ready[0]),
        .o_valid    (link_valid[0]),
        .o_data     (link_data[0])
    );

    // Each cell performs one vectoring rotation with its own fixed shift and
    // table angle, then hands the vector and the angle sum to its neighbor.
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        chxy_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_up_valid (link_valid[k]),
            .i_up_data  (link_data[k]),
            .o_up_ready (link_ready[k]),
            .i_dn_ready (link_ready[k+1]),
            .o_valid    (link_valid[k+1]),
            .o_data     (link_data[k+1])
        );
    end

    // The last cell brings the angle into one turn, rounds it to the output
    // unit and holds the heading word until the sink takes it.
    chxy_final #(
        .FRAC_BITS (FRAC_BITS)
    ) u_final (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (link_valid[N_CELLS]),
        .i_up_data  (link_data[N_CELLS]),
        .o_up_ready (link_ready[N_CELLS]),
        .o_hdg      (o_hdg)
    );

endmodule

// ===== test/tb_compass_heading_from_xy_unit.sv =====
`timescale 1ns / 1ps

module tb_compass_heading_from_xy_unit;
    import chxy_pkg::*;

    // Parameters of the unit under test. The heading predictor below uses the same values.
    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 6;

    // The random part has 1250 readings. The directed part comes before it.
    localparam int RANDOM_READINGS = 1250;

    // This is a bound for the whole run. A slow but correct run has about 1300 words, and
    // each word can wait out the longest input gap and the longest output stall. The bound
    // is several times what that gives.
    localparam int CYCLE_LIMIT = 600000;

    // The drain at the end waits longer than a heading takes to pass the entry cell, the
    // rotation cells and the rounding cell, so any stray extra word still shows up.
    localparam int DRAIN_CYCLES = CORDIC_STAGES + 12;

    typedef struct {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
    } t_reading;

    logic i_clk;
    logic i_rst_n;

    chxy_in_if  xy ();
    chxy_out_if hdg ();

    compass_heading_from_xy_unit #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRAC_BITS     (FRAC_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_xy    (xy),
        .o_hdg   (hdg)
    );

    // Readings that still wait to be driven, and headings that are predicted but not yet seen.
    t_reading          readings_to_send[$];
    logic [HDG_W-1:0]  headings_due[$];

    int  readings_queued = 0;
    int  readings_taken  = 0;
    int  mismatches      = 0;
    int  cycle_count     = 0;

    // This flag is set at a rising edge when the input word is taken. The driver reads it
    // at the next falling edge.
    bit  xy_taken        = 1'b0;

    // These counters control idling on each side. A nonzero calm count means a stretch
    // with no idling is in progress.
    int  in_gap_left     = 0;
    int  in_calm_left    = 0;
    int  out_stall_left  = 0;
    int  out_calm_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // This is the heading predictor. A vectoring rotation finds atan2(y, x) in units of
    // 2^-20 degree. The result is folded into [0, 360), rounded half up to
    // 2^-FRAC_BITS degree, and 360 wraps to 0.
    function automatic logic [HDG_W-1:0] heading_of(logic signed [XY_W-1:0] x_in,
                                                    logic signed [XY_W-1:0] y_in);
        longint xs;
        longint ys;
        longint ang;
        longint dx;
        longint dy;
        longint h;
        longint full;
        int     sh;
        full = longint'(360) << FRAC_BITS;
        if (y_in == 0) begin
            // When Y is zero the rotation is skipped and the answer is exact.
            h = (x_in < 0) ? (longint'(180) << FRAC_BITS) : 0;
        end else begin
            xs  = longint'(x_in) << PRESCALE_SH;
            ys  = longint'(y_in) << PRESCALE_SH;
            ang = 0;
            // When X is negative, turn the vector by half a circle first.
            if (xs < 0) begin
                xs  = -xs;
                ys  = -ys;
                ang = longint'(180) << ANG_FRAC;
            end
            for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
                dx = ys >>> i;
                dy = xs >>> i;
                if (ys > 0) begin
                    xs  = xs + dx;
                    ys  = ys - dy;
                    ang = ang + longint'(ATAN_TAB[i]);
                end else begin
                    xs  = xs - dx;
                    ys  = ys + dy;
                    ang = ang - longint'(ATAN_TAB[i]);
                end
            end
            if (ang < 0) begin
                ang = ang + (longint'(360) << ANG_FRAC);
            end
            if (ang < 0) begin
                ang = 0;
            end
            sh = ANG_FRAC - FRAC_BITS;
            if (sh > 0) begin
                ang = (ang + (longint'(1) << (sh - 1))) >>> sh;
            end
            h = ang;
        end
        if (h >= full) begin
            h = h - full;
        end
        return h[HDG_W-1:0];
    endfunction

    // This picks the idle length before the next word on one side of the unit. Most gaps
    // are zero or short and a few are long. Now and then a calm stretch starts, and during
    // it the side does not idle.
    function automatic int pick_pause(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(30, 150);
            return 0;
        end
        if (r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_reading(logic signed [XY_W-1:0] x, logic signed [XY_W-1:0] y);
        t_reading rd;
        rd.x = x;
        rd.y = y;
        readings_to_send.push_back(rd);
        readings_queued++;
    endfunction

    // This picks a value near the extremes of a signed 16-bit reading or near zero.
    function automatic logic signed [XY_W-1:0] edge_value();
        case ($urandom_range(0, 6))
            0:       return -16'sd32768;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            5:       return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver. It runs on the falling edge and feeds words from the queue of pending
    // readings. A word stays on the bus with valid held high until the unit takes it. After
    // that the driver may idle before the next word.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            xy.valid <= 1'b0;
        end else if (!xy.valid || xy_taken) begin
            if (in_gap_left > 0) begin
                in_gap_left--;
                xy.valid <= 1'b0;
            end else if (readings_to_send.size() > 0) begin
                xy.x_field  <= readings_to_send[0].x;
                xy.y_field  <= readings_to_send[0].y;
                xy.valid    <= 1'b1;
                void'(readings_to_send.pop_front());
                in_gap_left  = pick_pause(in_calm_left);
            end else begin
                xy.valid <= 1'b0;
            end
        end
    end

    // The output side drops ready in random stalls, also on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hdg.ready <= 1'b0;
        end else if (out_stall_left > 0) begin
            out_stall_left--;
            hdg.ready <= 1'b0;
        end else begin
            hdg.ready     <= 1'b1;
            out_stall_left = pick_pause(out_calm_left);
        end
    end

    // ------------------------------------------------------------------
    // This block samples on the rising edge. It predicts a heading for each input word the
    // unit takes. It checks each output word against the oldest prediction. It also bounds
    // the length of the run.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && hdg.valid && hdg.ready) begin
            if (headings_due.size() == 0) begin
                $error("heading: no word expected, actual %0d", hdg.heading);
                mismatches++;
            end else begin
                if (hdg.heading !== headings_due[0]) begin
                    $error("heading: expected %0d, actual %0d", headings_due[0], hdg.heading);
                    mismatches++;
                end
                void'(headings_due.pop_front());
            end
        end
        xy_taken = i_rst_n && xy.valid && xy.ready;
        if (xy_taken) begin
            headings_due.push_back(heading_of(xy.x_field, xy.y_field));
            readings_taken++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int r;
        logic signed [XY_W-1:0] rx;
        logic signed [XY_W-1:0] ry;

        // All inputs of the unit are known from time zero.
        i_rst_n     = 1'b0;
        xy.valid    = 1'b0;
        xy.x_field  = '0;
        xy.y_field  = '0;
        hdg.ready   = 1'b0;

        // The directed part comes first.
        // On the axis where Y is zero the answer is exact: 0 for X >= 0 and 180 for X < 0.
        queue_reading(16'sd0, 16'sd0);
        queue_reading(16'sd32767, 16'sd0);
        queue_reading(-16'sd32768, 16'sd0);
        queue_reading(16'sd5, 16'sd0);
        queue_reading(-16'sd1, 16'sd0);
        // When X is zero, the reading counts as non-negative and the rotation gives about
        // 90 or 270 degrees.
        queue_reading(16'sd0, 16'sd32767);
        queue_reading(16'sd0, -16'sd32768);
        queue_reading(16'sd0, 16'sd1);
        queue_reading(16'sd0, -16'sd1);
        // These corners use the most negative values, where negation needs the full width.
        queue_reading(16'sd32767, 16'sd32767);
        queue_reading(-16'sd32768, -16'sd32768);
        queue_reading(-16'sd32768, 16'sd32767);
        queue_reading(16'sd32767, -16'sd32768);
        queue_reading(-16'sd32768, 16'sd1);
        queue_reading(-16'sd1, -16'sd32768);
        // These are unit vectors in all four quadrants.
        queue_reading(16'sd1, 16'sd1);
        queue_reading(-16'sd1, -16'sd1);
        queue_reading(-16'sd1, 16'sd1);
        queue_reading(16'sd1, -16'sd1);
        // Angles just below 360 wrap to 0 after rounding; one just above 0 rounds to 0.
        queue_reading(16'sd32767, -16'sd1);
        queue_reading(16'sd20000, -16'sd1);
        queue_reading(16'sd32767, 16'sd1);
        // This angle is just around 180 degrees.
        queue_reading(-16'sd32768, -16'sd1);

        // The random part follows. It mixes full-range words with small vectors, readings
        // on the axes, extreme values, and near-axis vectors that test the wrap at 360.
        for (int n = 0; n < RANDOM_READINGS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                rx = XY_W'($urandom);
                ry = XY_W'($urandom);
            end else if (r < 60) begin
                rx = XY_W'($urandom_range(0, 127) - 64);
                ry = XY_W'($urandom_range(0, 127) - 64);
            end else if (r < 70) begin
                rx = XY_W'($urandom);
                ry = 16'sd0;
            end else if (r < 78) begin
                rx = 16'sd0;
                ry = XY_W'($urandom);
            end else if (r < 86) begin
                rx = edge_value();
                ry = edge_value();
            end else begin
                rx = XY_W'($urandom);
                ry = XY_W'($urandom_range(0, 6) - 3);
            end
            queue_reading(rx, ry);
        end

        // Reset is held low from time zero, then released on a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word has been taken and every heading has come back.
        while (readings_taken < readings_queued || headings_due.size() > 0) begin
            @(posedge i_clk);
        end
        // Drain for longer than the pipeline depth, so any extra output word is caught.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
